// ===== design/double_ended_queue_assert.svh =====
// ----------------------------------------------------------------------------
// Double-ended queue assertion macros
// Clocked assertion helpers used by the file that checks the queue.
// ----------------------------------------------------------------------------
`ifndef DOUBLE_ENDED_QUEUE_ASSERT_SVH
`define DOUBLE_ENDED_QUEUE_ASSERT_SVH

// A property checked on every rising edge of i_clk, idle while reset is held.
`define DEQ_ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// A condition that must never be seen on a rising edge of i_clk.
`define DEQ_ASSERT_NEVER(lbl, cond, msg) \
    `DEQ_ASSERT_CLK(lbl, !(cond), msg)

`endif

// ===== design/deq_pkg.sv =====
// ----------------------------------------------------------------------------
// Double-ended queue package
// Payload types, operation and status codes, and controller types.
// ----------------------------------------------------------------------------
package deq_pkg;

    localparam int DEPTH_DEFAULT = 16;
    localparam int DATA_W        = 32;

    // Operation codes carried in the opcode field.
    localparam logic [2:0] OP_PEEK       = 3'd0;
    localparam logic [2:0] OP_PUSH_FRONT = 3'd1;
    localparam logic [2:0] OP_PUSH_BACK  = 3'd2;
    localparam logic [2:0] OP_POP_FRONT  = 3'd3;
    localparam logic [2:0] OP_POP_BACK   = 3'd4;
    localparam logic [2:0] OP_CLEAR      = 3'd5;
    localparam logic [2:0] OP_REVERSE    = 3'd6;

    // Status codes reported with every result.
    localparam logic [1:0] STAT_DONE  = 2'd0;
    localparam logic [1:0] STAT_FULL  = 2'd1;
    localparam logic [1:0] STAT_EMPTY = 2'd2;

    typedef struct packed {
        logic [2:0]               opcode;
        logic signed [DATA_W-1:0] data_value;
    } t_in;

    typedef struct packed {
        logic signed [DATA_W-1:0] front_value;
        logic signed [DATA_W-1:0] back_value;
        logic [4:0]               item_count;
        logic                     is_empty;
        logic [1:0]               status;
    } t_out;

    typedef enum logic [1:0] {
        S_IDLE,
        S_LOAD,
        S_DONE
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic exec;
        logic load_rd;
        logic out_load;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic pop_ok;
    } t_dp_stat;

endpackage

// ===== design/double_ended_queue.sv =====
// ----------------------------------------------------------------------------
// Double-ended queue
// Ring-buffer deque of signed words with push, pop, clear and reverse.
// ----------------------------------------------------------------------------
// The input channel (i_in_valid, o_in_ready, i_in_data) carries one operation
// per transaction: an opcode and a word to push. The output channel
// (o_out_valid, i_out_ready, o_out_data) returns exactly one result per
// operation: the front and back words (all ones when empty), the count, an
// empty flag and a status that flags a rejected push or an ignored pop.
// An operation is executed on the edge at which it is accepted; its result
// enters the output register from the done state, after a read-back state
// for a pop that succeeds, since the new end word is then read back from the
// storage RAM through its registered read port. The controller holds one
// operation at a time, so a new transaction is taken only once the result of
// the last one has been handed over into the output register.
// When the receiver stalls, the finished result waits in the output register
// and one further operation may be accepted and executed; its result then
// waits in the controller until the output register is free.
// Synchronous reset empties the queue and clears the reversed flag; the
// storage RAM itself is not cleared, as no word is read before it is written.
// ----------------------------------------------------------------------------
`include "double_ended_queue_assert.svh"

module double_ended_queue #(
    parameter int DEPTH = deq_pkg::DEPTH_DEFAULT
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  deq_pkg::t_in  i_in_data,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output deq_pkg::t_out o_out_data
);

    // Commands from the controller and status back from the datapath.
    deq_pkg::t_dp_cmd  dp_cmd;
    deq_pkg::t_dp_stat dp_stat;

    // The controller sequences each transaction: execute on acceptance,
    // an optional read-back state for pops that succeed, then the output hand-over.
    deq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_stat      (dp_stat),
        .o_cmd       (dp_cmd)
    );

    // The datapath holds the ring storage, the head pointer, the count, the
    // reversed flag and cached copies of the physical first and last words.
    deq_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (dp_cmd),
        .i_in_data  (i_in_data),
        .o_stat     (dp_stat),
        .o_out_data (o_out_data)
    );

    // An empty queue must always report all ones at both ends.
    `DEQ_ASSERT_CLK(a_empty_ends, (o_out_valid && o_out_data.is_empty) |-> ((o_out_data.front_value == '1) && (o_out_data.back_value == '1)), "empty queue reported a word")

    // Only one operation is in flight: acceptance drops ready on the next cycle.
    `DEQ_ASSERT_CLK(a_one_in_flight, (i_in_valid && o_in_ready) |=> !o_in_ready, "second transaction accepted while busy")

    // A push can only be rejected when the queue holds words.
    `DEQ_ASSERT_NEVER(a_full_not_empty, o_out_valid && (o_out_data.status == deq_pkg::STAT_FULL) && o_out_data.is_empty, "push rejected on an empty queue")

endmodule

// ===== design/deq_ctrl.sv =====
// ----------------------------------------------------------------------------
// Double-ended queue controller
// Sequences one transaction at a time through execute, read-back and output.
// ----------------------------------------------------------------------------
module deq_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    input  deq_pkg::t_dp_stat i_stat,
    output deq_pkg::t_dp_cmd  o_cmd
);

    deq_pkg::t_state r_state;
    deq_pkg::t_state n_state;
    logic            r_out_valid;
    logic            out_free;

    assign out_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            deq_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_state = i_stat.pop_ok ? deq_pkg::S_LOAD : deq_pkg::S_DONE;
                end
            end
            deq_pkg::S_LOAD: begin
                n_state = deq_pkg::S_DONE;
            end
            deq_pkg::S_DONE: begin
                if (out_free) begin
                    n_state = deq_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = deq_pkg::S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd          = '0;
        o_in_ready     = 1'b0;
        unique case (r_state)
            deq_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.exec = i_in_valid;
            end
            deq_pkg::S_LOAD: begin
                o_cmd.load_rd = 1'b1;
            end
            deq_pkg::S_DONE: begin
                o_cmd.out_load = out_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= deq_pkg::S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

// ===== design/deq_datapath.sv =====
// ----------------------------------------------------------------------------
// Double-ended queue datapath
// Ring buffer storage, pointers, cached end words and the result register.
// ----------------------------------------------------------------------------
module deq_datapath #(
    parameter int DEPTH = deq_pkg::DEPTH_DEFAULT
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  deq_pkg::t_dp_cmd  i_cmd,
    input  deq_pkg::t_in      i_in_data,
    output deq_pkg::t_dp_stat o_stat,
    output deq_pkg::t_out     o_out_data
);

    localparam int IW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [deq_pkg::DATA_W-1:0] r_mem [DEPTH];
    logic [deq_pkg::DATA_W-1:0] r_rd_data;
    logic [deq_pkg::DATA_W-1:0] r_first;
    logic [deq_pkg::DATA_W-1:0] r_last;
    logic [deq_pkg::DATA_W-1:0] n_first;
    logic [deq_pkg::DATA_W-1:0] n_last;
    logic [IW-1:0]              r_head;
    logic [IW-1:0]              n_head;
    logic [CW-1:0]              r_count;
    logic [CW-1:0]              n_count;
    logic                       r_rev;
    logic                       n_rev;
    logic [1:0]                 r_status;
    logic [1:0]                 n_status;
    logic                       r_rd_to_first;
    deq_pkg::t_out              r_out;
    deq_pkg::t_out              n_out;

    logic [2:0]    op;
    logic          is_push;
    logic          is_pop;
    logic          at_start;
    logic          full;
    logic          empty;
    logic          push_ok;
    logic          pop_ok;
    logic [IW-1:0] head_dec;
    logic [IW-1:0] head_inc;
    logic [CW:0]   sum_end;
    logic [IW-1:0] end_slot;
    logic [IW-1:0] last_slot;
    logic [IW-1:0] last_dec;
    logic          wr_en;
    logic [IW-1:0] wr_addr;
    logic          rd_en;
    logic [IW-1:0] rd_addr;

    assign op      = i_in_data.opcode;
    assign is_push = (op == deq_pkg::OP_PUSH_FRONT) || (op == deq_pkg::OP_PUSH_BACK);
    assign is_pop  = (op == deq_pkg::OP_POP_FRONT) || (op == deq_pkg::OP_POP_BACK);
    // A logical front operation works at the physical start unless reversed.
    assign at_start = (is_push ? (op == deq_pkg::OP_PUSH_FRONT)
                               : (op == deq_pkg::OP_POP_FRONT)) ^ r_rev;
    assign full    = (r_count == CW'(DEPTH));
    assign empty   = (r_count == '0);
    assign push_ok = is_push && !full;
    assign pop_ok  = is_pop && !empty;

    assign head_dec = (r_head == '0) ? IW'(DEPTH - 1) : r_head - 1'b1;
    assign head_inc = (r_head == IW'(DEPTH - 1)) ? '0 : r_head + 1'b1;

    // Slot after the physical last word, wrapped by one compare and subtract.
    assign sum_end  = (CW+1)'(r_head) + (CW+1)'(r_count);
    assign end_slot = (sum_end >= (CW+1)'(DEPTH)) ? IW'(sum_end - (CW+1)'(DEPTH))
                                                  : IW'(sum_end);
    assign last_slot = (end_slot == '0) ? IW'(DEPTH - 1) : end_slot - 1'b1;
    assign last_dec  = (last_slot == '0) ? IW'(DEPTH - 1) : last_slot - 1'b1;

    assign o_stat.pop_ok = pop_ok;

    always_comb begin
        n_head   = r_head;
        n_count  = r_count;
        n_rev    = r_rev;
        n_status = r_status;
        n_first  = r_first;
        n_last   = r_last;
        wr_en    = 1'b0;
        wr_addr  = end_slot;
        rd_en    = 1'b0;
        rd_addr  = head_inc;
        if (i_cmd.exec) begin
            n_status = deq_pkg::STAT_DONE;
            if (is_push) begin
                if (full) begin
                    n_status = deq_pkg::STAT_FULL;
                end else begin
                    wr_en   = 1'b1;
                    n_count = r_count + 1'b1;
                    if (at_start) begin
                        n_head  = head_dec;
                        wr_addr = head_dec;
                        n_first = i_in_data.data_value;
                        if (empty) begin
                            n_last = i_in_data.data_value;
                        end
                    end else begin
                        n_last = i_in_data.data_value;
                        if (empty) begin
                            n_first = i_in_data.data_value;
                        end
                    end
                end
            end else if (is_pop) begin
                if (empty) begin
                    n_status = deq_pkg::STAT_EMPTY;
                end else begin
                    rd_en   = 1'b1;
                    n_count = r_count - 1'b1;
                    if (at_start) begin
                        n_head = head_inc;
                    end else begin
                        rd_addr = last_dec;
                    end
                end
            end else if (op == deq_pkg::OP_CLEAR) begin
                n_count = '0;
                n_head  = '0;
            end else if (op == deq_pkg::OP_REVERSE) begin
                n_rev = !r_rev;
            end
        end
        if (i_cmd.load_rd) begin
            if (r_rd_to_first) begin
                n_first = r_rd_data;
            end else begin
                n_last = r_rd_data;
            end
        end
    end

    always_comb begin
        n_out.item_count = 5'(r_count);
        n_out.is_empty   = (r_count == '0);
        n_out.status     = r_status;
        if (r_count == '0) begin
            n_out.front_value = '1;
            n_out.back_value  = '1;
        end else if (r_rev) begin
            n_out.front_value = r_last;
            n_out.back_value  = r_first;
        end else begin
            n_out.front_value = r_first;
            n_out.back_value  = r_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= i_in_data.data_value;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head   <= '0;
            r_count  <= '0;
            r_rev    <= 1'b0;
            r_status <= deq_pkg::STAT_DONE;
        end else begin
            r_head   <= n_head;
            r_count  <= n_count;
            r_rev    <= n_rev;
            r_status <= n_status;
        end
    end

    always_ff @(posedge i_clk) begin
        r_first <= n_first;
        r_last  <= n_last;
        if (rd_en) begin
            r_rd_to_first <= at_start;
        end
        if (i_cmd.out_load) begin
            r_out <= n_out;
        end
    end

    assign o_out_data = r_out;

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Double-ended queue testbench
// Drives opcode transactions into the queue, keeps a ring-buffer predictor of
// its contents and compares every returned result field by field, under
// changing idle and stall patterns on both channels.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int         QUEUE_DEPTH  = deq_pkg::DEPTH_DEFAULT;
    localparam int         QUIET_LIMIT  = 2000;
    localparam int         SETTLE_TIME  = 8;
    // The opcode field is three bits wide; its top code is unused and acts as
    // a peek, so it gets a name of its own here.
    localparam logic [2:0] OP_UNUSED    = 3'd7;
    localparam logic signed [deq_pkg::DATA_W-1:0] WORD_MIN = 32'sh8000_0000;
    localparam logic signed [deq_pkg::DATA_W-1:0] WORD_MAX = 32'sh7FFF_FFFF;

    // ------------------------------------------------------------------------
    // Clock, reset and the block's ports. Every input is known from time zero.
    // ------------------------------------------------------------------------
    logic          i_clk       = 1'b0;
    logic          i_rst_n     = 1'b0;
    logic          i_in_valid  = 1'b0;
    logic          o_in_ready;
    deq_pkg::t_in  i_in_data   = '0;
    logic          o_out_valid;
    logic          i_out_ready = 1'b0;
    deq_pkg::t_out o_out_data;

    always #4 i_clk = ~i_clk;

    double_ended_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    // ------------------------------------------------------------------------
    // Predictor state: a private copy of the ring buffer, its head slot, the
    // word count and the direction flag that reverse toggles.
    // ------------------------------------------------------------------------
    logic signed [deq_pkg::DATA_W-1:0] ring_words [QUEUE_DEPTH];
    int                                ring_head;
    int                                ring_count;
    bit                                ring_reversed;

    // Results predicted for accepted transactions, oldest first.
    deq_pkg::t_out expected_results [$];

    // Knobs shared by the sender, the receiver and the test tasks.
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_cycles    = 0;

    // Statistics and failure count.
    int mismatch_count = 0;
    int ops_accepted   = 0;
    int results_seen   = 0;
    int full_rejects   = 0;
    int empty_pops     = 0;
    int reverse_count  = 0;
    int full_reached   = 0;

    // ------------------------------------------------------------------------
    // Predictor. Applies one operation to the ring copy and returns the result
    // the block must report for it. A push goes to the physical start of the
    // ring when it targets the logical front and the queue is not reversed, or
    // the logical back and it is; pops follow the same rule.
    // ------------------------------------------------------------------------
    function automatic deq_pkg::t_out apply_deque_op(input deq_pkg::t_in op_item);
        deq_pkg::t_out                     res;
        logic [1:0]                        stat;
        bit                                at_start;
        logic signed [deq_pkg::DATA_W-1:0] first_word;
        logic signed [deq_pkg::DATA_W-1:0] last_word;
        stat = deq_pkg::STAT_DONE;
        case (op_item.opcode)
            deq_pkg::OP_PUSH_FRONT, deq_pkg::OP_PUSH_BACK: begin
                if (ring_count >= QUEUE_DEPTH) begin
                    stat = deq_pkg::STAT_FULL;
                end else begin
                    at_start = (op_item.opcode == deq_pkg::OP_PUSH_FRONT) != ring_reversed;
                    if (at_start) begin
                        ring_head = (ring_head + QUEUE_DEPTH - 1) % QUEUE_DEPTH;
                        ring_words[ring_head] = op_item.data_value;
                    end else begin
                        ring_words[(ring_head + ring_count) % QUEUE_DEPTH] =
                            op_item.data_value;
                    end
                    ring_count++;
                end
            end
            deq_pkg::OP_POP_FRONT, deq_pkg::OP_POP_BACK: begin
                if (ring_count == 0) begin
                    stat = deq_pkg::STAT_EMPTY;
                end else begin
                    at_start = (op_item.opcode == deq_pkg::OP_POP_FRONT) != ring_reversed;
                    if (at_start) begin
                        ring_head = (ring_head + 1) % QUEUE_DEPTH;
                    end
                    ring_count--;
                end
            end
            deq_pkg::OP_CLEAR: begin
                // The direction flag survives a clear.
                ring_count = 0;
                ring_head  = 0;
            end
            deq_pkg::OP_REVERSE: begin
                ring_reversed = !ring_reversed;
            end
            default: begin
            end
        endcase

        res.front_value = -1;
        res.back_value  = -1;
        if (ring_count != 0) begin
            first_word = ring_words[ring_head];
            last_word  = ring_words[(ring_head + ring_count + QUEUE_DEPTH - 1) % QUEUE_DEPTH];
            res.front_value = ring_reversed ? last_word  : first_word;
            res.back_value  = ring_reversed ? first_word : last_word;
        end
        res.item_count = ring_count[4:0];
        res.is_empty   = (ring_count == 0);
        res.status     = stat;
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // Sender. Called just after a rising edge. It may first idle for a random
    // number of cycles, then offers the transaction and holds it until the
    // block accepts it. Valid is left high on return, so that a following
    // transaction can go out back to back; whoever pauses lowers it.
    // ------------------------------------------------------------------------
    task automatic send_op(input logic [2:0] opcode,
                           input logic signed [deq_pkg::DATA_W-1:0] word);
        deq_pkg::t_in  op_item;
        deq_pkg::t_out res;
        op_item.opcode     = opcode;
        op_item.data_value = word;
        if ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
            while ($urandom_range(99) < send_idle_pct) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= op_item;
        do @(posedge i_clk); while (!o_in_ready);

        // Accepted on this edge: work out what the block must report.
        res = apply_deque_op(op_item);
        expected_results.insert(expected_results.size(), res);
        ops_accepted++;
        if (res.status == deq_pkg::STAT_FULL)  full_rejects++;
        if (res.status == deq_pkg::STAT_EMPTY) empty_pops++;
        if (opcode == deq_pkg::OP_REVERSE)     reverse_count++;
        if (ring_count == QUEUE_DEPTH && res.status == deq_pkg::STAT_DONE &&
            (opcode == deq_pkg::OP_PUSH_FRONT || opcode == deq_pkg::OP_PUSH_BACK)) begin
            full_reached++;
        end
    endtask

    // Lowers valid and waits until every outstanding result has come back.
    task automatic wait_all_results();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (expected_results.size() != 0) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------------
    // Receiver and checker. Ready is redrawn every cycle, unless a hold-off
    // is running, in which case ready stays low and the counter runs down.
    // ------------------------------------------------------------------------
    task automatic report_field(input string field_name,
                                input logic [deq_pkg::DATA_W-1:0] exp_val,
                                input logic [deq_pkg::DATA_W-1:0] act_val);
        if (exp_val !== act_val) begin
            mismatch_count++;
            $display("%0t: %s mismatch, expected %h, actual %h",
                     $time, field_name, exp_val, act_val);
        end
    endtask

    always @(posedge i_clk) begin
        deq_pkg::t_out exp_res;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            results_seen++;
            if (expected_results.size() == 0) begin
                mismatch_count++;
                $display("%0t: result with no transaction outstanding, expected none, actual %h",
                         $time, o_out_data);
            end else begin
                exp_res = expected_results[0];
                expected_results.delete(0);
                report_field("front_value", exp_res.front_value, o_out_data.front_value);
                report_field("back_value",  exp_res.back_value,  o_out_data.back_value);
                report_field("item_count",  exp_res.item_count,  o_out_data.item_count);
                report_field("is_empty",    exp_res.is_empty,    o_out_data.is_empty);
                report_field("status",      exp_res.status,      o_out_data.status);
            end
        end
        if (hold_cycles > 0) begin
            hold_cycles--;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: ends the run when no transaction moves on either channel for
    // too long.
    // ------------------------------------------------------------------------
    int quiet_cycles = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("%0t: no transaction for %0d cycles", $time, QUIET_LIMIT);
            $display("tb_top NOT OK");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers.
    // ------------------------------------------------------------------------
    // Mostly random words, with the extremes of the signed range mixed in.
    function automatic logic signed [deq_pkg::DATA_W-1:0] pick_word();
        case ($urandom_range(15))
            0:       return WORD_MIN;
            1:       return WORD_MAX;
            2:       return -1;
            3:       return 0;
            default: return $urandom;
        endcase
    endfunction

    // While filling, pushes dominate; while draining, pops do. A small share
    // of clears, reverses, peeks and the unused code is mixed in either way.
    function automatic logic [2:0] pick_op(input bit filling);
        int roll;
        roll = $urandom_range(99);
        if (roll < 2)  return deq_pkg::OP_CLEAR;
        if (roll < 5)  return OP_UNUSED;
        if (roll < 10) return deq_pkg::OP_PEEK;
        if (roll < 18) return deq_pkg::OP_REVERSE;
        if (($urandom_range(99) < 70) == filling) begin
            return $urandom_range(1) ? deq_pkg::OP_PUSH_FRONT : deq_pkg::OP_PUSH_BACK;
        end
        return $urandom_range(1) ? deq_pkg::OP_POP_FRONT : deq_pkg::OP_POP_BACK;
    endfunction

    // ------------------------------------------------------------------------
    // Test tasks.
    // ------------------------------------------------------------------------
    // Operations on an empty queue: both pops are ignored and flagged, reverse
    // flips the direction with nothing to show, and the unused code peeks.
    task automatic test_empty_queue_ops();
        send_op(deq_pkg::OP_PEEK,      32'sd5);
        send_op(deq_pkg::OP_POP_FRONT, 32'sd0);
        send_op(deq_pkg::OP_POP_BACK,  32'sd0);
        send_op(deq_pkg::OP_REVERSE,   32'sd0);
        send_op(OP_UNUSED,             WORD_MAX);
        wait_all_results();
    endtask

    // Pushes at both ends with extreme words, then reverse and pop from each
    // end, so the swapped roles of front and back are seen.
    task automatic test_end_ops();
        send_op(deq_pkg::OP_PUSH_FRONT, WORD_MAX);
        send_op(deq_pkg::OP_PUSH_BACK,  WORD_MIN);
        send_op(deq_pkg::OP_REVERSE,    32'sd0);
        send_op(deq_pkg::OP_POP_FRONT,  32'sd0);
        send_op(deq_pkg::OP_POP_BACK,   32'sd0);
        wait_all_results();
    endtask

    // Fills the queue, checks that pushes at either end are then rejected,
    // and clears it again.
    task automatic test_full_queue();
        for (int n = 0; n < QUEUE_DEPTH; n++) begin
            send_op(n[0] ? deq_pkg::OP_PUSH_BACK : deq_pkg::OP_PUSH_FRONT,
                    (n == 0) ? -1 : (n == 1) ? 32'sd0 : pick_word());
        end
        send_op(deq_pkg::OP_PUSH_BACK,  WORD_MIN);
        send_op(deq_pkg::OP_PUSH_FRONT, WORD_MAX);
        send_op(deq_pkg::OP_CLEAR,      32'sd0);
        wait_all_results();
    endtask

    // The receiver holds off for a long stretch while the sender keeps
    // offering transactions, so the block fills its output stage and stops
    // taking input until ready returns.
    task automatic test_output_hold_off();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_cycles    = 64;
        for (int n = 0; n < 12; n++) begin
            send_op(pick_op(1'b1), pick_word());
        end
        wait_all_results();
    endtask

    // Random traffic under the given idle and stall rates. The mode flips
    // between filling and draining, only once the queue is full or empty,
    // so both limits are reached many times.
    task automatic test_random_traffic(input int num_ops, input int idle_pct,
                                       input int stall_pct);
        bit filling;
        filling        = 1'b1;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        for (int n = 0; n < num_ops; n++) begin
            if (ring_count == QUEUE_DEPTH && $urandom_range(1)) filling = 1'b0;
            if (ring_count == 0 && $urandom_range(1))           filling = 1'b1;
            send_op(pick_op(filling), pick_word());
        end
        // The sender pauses here until every result of the phase is back.
        wait_all_results();
    endtask

    // ------------------------------------------------------------------------
    // Main sequence.
    // ------------------------------------------------------------------------
    initial begin
        ring_head     = 0;
        ring_count    = 0;
        ring_reversed = 1'b0;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_empty_queue_ops();
        test_end_ops();
        test_full_queue();
        test_output_hold_off();
        test_random_traffic(250, 0,  0);
        test_random_traffic(250, 77, 0);
        test_random_traffic(250, 0,  77);
        test_random_traffic(250, 16, 16);

        // Let any stray result show itself before the verdict.
        recv_stall_pct = 0;
        repeat (SETTLE_TIME) @(posedge i_clk);

        $display("Ran %0d operations (%0d results); %0d pushes rejected when full, ",
                 ops_accepted, results_seen, full_rejects);
        $display("%0d pops on empty, %0d reverses, queue filled %0d times.",
                 empty_pops, reverse_count, full_reached);
        if (mismatch_count == 0 && expected_results.size() == 0) begin
            $display("tb_top OK");
        end else begin
            $display("tb_top NOT OK");
        end
        $finish;
    end

endmodule
